@@ design/ihrl_pkg.sv @@
// Shared types, field positions, record kinds and the hex digit decoder for the HEX record loader.
`default_nettype none

package ihrl_pkg;

    localparam logic [7:0] CHAR_LF = 8'h0A;

    // Character positions within one record line.
    localparam logic [3:0] POS_MARK       = 4'd0;
    localparam logic [3:0] POS_LENGTH_END = 4'd2;
    localparam logic [3:0] POS_OFFSET_END = 4'd6;
    localparam logic [3:0] POS_KIND_END   = 4'd8;
    localparam logic [3:0] POS_DATA_HI    = 4'd9;
    localparam logic [3:0] POS_DATA_LO    = 4'd10;
    localparam logic [3:0] POS_EXT_END    = 4'd12;

    localparam logic [7:0] KIND_DATA    = 8'h00;
    localparam logic [7:0] KIND_SEGMENT = 8'h02;
    localparam logic [7:0] KIND_LINEAR  = 8'h04;

    // One table entry holds the segment start above its length.
    localparam int ENTRY_W = 64;

    typedef struct packed {
        logic start;
        logic emit;
    } seg_req_t;

    typedef struct packed {
        logic busy;
        logic opened;
        logic dropped;
    } seg_status_t;

    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [3:0] n;
        n = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            n = c[3:0];
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            n = c[3:0] + 4'd9;
        end
        return n;
    endfunction

endpackage

`default_nettype wire

@@ design/intel_hex_record_loader_unit.sv @@
// Top level of the HEX record loader: character parser, segment table and result register.
//
//  channel  dir  handshake            payload
//  s_       in   s_tvalid / s_tready  s_tdata: character; s_tuser: file_start
//  m_       out  m_tvalid / m_tready  m_tdata: address, byte, index, total; m_tuser: flags
//
// A character is taken while the segment table is idle and the result register is free or being emptied.
// The character that ends the type field of a data record starts a walk of the segment
// table RAM (one read port), which reads and compares the filled entries in turn until a
// match or a miss; the walk holds the input off. A stalled result holds the input off.
// Reset clears control state only; table entries at or beyond the fill count are never compared.
`default_nettype none

module intel_hex_record_loader_unit #(
    parameter int MAX_SEGMENTS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] character
    input  wire logic        s_tuser,   // [0] file_start
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata,   // [31:0] byte_address, [39:32] data_byte,
                                        // [43:40] segment_index, [75:44] total_bytes, rest 0
    output logic [1:0]       m_tuser    // [0] segment_opened, [1] table_full
);
    import ihrl_pkg::*;

    localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

    logic [3:0]  pos_reg, pos_next;
    logic [7:0]  length_reg, length_next;
    logic [15:0] offset_reg, offset_next;
    logic [7:0]  kind_reg, kind_next;
    logic [15:0] acc_reg, acc_next;
    logic [31:0] seg_base_reg, seg_base_next;
    logic [31:0] lin_base_reg, lin_base_next;
    logic [31:0] base_sum_reg, base_sum_next;
    logic [7:0]  count_reg, count_next;
    logic [16:0] rec_addr_reg, rec_addr_next;
    logic [31:0] total_reg, total_next;

    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_addr_reg, out_addr_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic [3:0]  out_index_reg, out_index_next;
    logic [31:0] out_total_reg, out_total_next;
    logic        out_opened_reg, out_opened_next;
    logic        out_full_reg, out_full_next;

    logic        accept;
    logic [3:0]  nib;
    logic [15:0] acc_shift;
    logic [7:0]  kind_new;
    logic [31:0] seg_base_eff;
    logic [31:0] lin_base_eff;
    logic [31:0] base_sum_eff;
    logic [31:0] total_eff;
    logic [31:0] ext_value;
    logic [31:0] seg_dst;

    seg_req_t         seg_req;
    seg_status_t      seg_status;
    logic [IDX_W-1:0] seg_index;
    logic [IDX_W+3:0] seg_index_ext;

    assign seg_index_ext = {4'd0, seg_index};

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = !seg_status.busy && (!out_valid_reg || m_tready);
    assign nib       = hex_nibble(s_tdata);
    assign acc_shift = {acc_reg[11:0], nib};
    assign kind_new  = acc_shift[7:0];

    assign seg_base_eff = s_tuser ? 32'd0 : seg_base_reg;
    assign lin_base_eff = s_tuser ? 32'd0 : lin_base_reg;
    assign base_sum_eff = s_tuser ? 32'd0 : base_sum_reg;
    assign total_eff    = s_tuser ? 32'd0 : total_reg;
    assign ext_value    = (kind_reg == KIND_SEGMENT) ? {12'd0, acc_shift, 4'd0}
                                                     : {acc_shift, 16'd0};
    assign seg_dst      = base_sum_eff + {16'd0, offset_reg};

    ihrl_seg_ctrl #(
        .MAX_SEGMENTS(MAX_SEGMENTS),
        .IDX_W       (IDX_W)
    ) u_seg_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (seg_req),
        .dst      (seg_dst),
        .status   (seg_status),
        .cur_index(seg_index)
    );

    always_comb begin
        pos_next       = pos_reg;
        length_next    = length_reg;
        offset_next    = offset_reg;
        kind_next      = kind_reg;
        acc_next       = acc_reg;
        seg_base_next  = seg_base_reg;
        lin_base_next  = lin_base_reg;
        base_sum_next  = base_sum_reg;
        count_next     = count_reg;
        rec_addr_next  = rec_addr_reg;
        total_next     = total_reg;
        seg_req.start  = 1'b0;
        seg_req.emit   = 1'b0;

        out_valid_next  = out_valid_reg && !m_tready;
        out_addr_next   = out_addr_reg;
        out_byte_next   = out_byte_reg;
        out_index_next  = out_index_reg;
        out_total_next  = out_total_reg;
        out_opened_next = out_opened_reg;
        out_full_next   = out_full_reg;

        if (accept) begin
            seg_base_next = seg_base_eff;
            lin_base_next = lin_base_eff;
            base_sum_next = base_sum_eff;
            total_next    = total_eff;

            if (s_tdata == CHAR_LF) begin
                pos_next = POS_MARK;
            end else if (pos_reg == POS_MARK) begin
                pos_next = 4'd1;
            end else if (pos_reg <= POS_KIND_END) begin
                acc_next = acc_shift;
                pos_next = pos_reg + 4'd1;
                if (pos_reg == POS_LENGTH_END) begin
                    length_next = acc_shift[7:0];
                    acc_next    = 16'd0;
                end else if (pos_reg == POS_OFFSET_END) begin
                    offset_next = acc_shift;
                    acc_next    = 16'd0;
                end else if (pos_reg == POS_KIND_END) begin
                    kind_next     = kind_new;
                    acc_next      = 16'd0;
                    count_next    = 8'd0;
                    rec_addr_next = {1'b0, offset_reg};
                    if (kind_new == KIND_DATA) begin
                        seg_req.start = 1'b1;
                        total_next    = total_eff + {24'd0, length_reg};
                    end
                end
            end else if (kind_reg == KIND_DATA) begin
                if (pos_reg == POS_DATA_HI) begin
                    acc_next = {12'd0, nib};
                    pos_next = POS_DATA_LO;
                end else begin
                    pos_next = POS_DATA_HI;
                    // Pairs beyond the record length are parsed but produce nothing.
                    if (count_reg < length_reg) begin
                        seg_req.emit    = 1'b1;
                        count_next      = count_reg + 8'd1;
                        rec_addr_next   = rec_addr_reg + 17'd1;
                        out_valid_next  = 1'b1;
                        out_addr_next   = base_sum_eff + {15'd0, rec_addr_reg};
                        out_byte_next   = {acc_reg[3:0], nib};
                        out_index_next  = seg_status.dropped ? 4'd0 : seg_index_ext[3:0];
                        out_opened_next = seg_status.opened && !seg_status.dropped;
                        out_full_next   = seg_status.dropped;
                        out_total_next  = total_eff;
                    end
                end
            end else if (kind_reg == KIND_SEGMENT || kind_reg == KIND_LINEAR) begin
                if (pos_reg <= POS_EXT_END) begin
                    acc_next = acc_shift;
                    pos_next = pos_reg + 4'd1;
                    if (pos_reg == POS_EXT_END) begin
                        acc_next = 16'd0;
                        if (kind_reg == KIND_SEGMENT) begin
                            seg_base_next = ext_value;
                            base_sum_next = lin_base_eff + ext_value;
                        end else begin
                            lin_base_next = ext_value;
                            base_sum_next = seg_base_eff + ext_value;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= POS_MARK;
            length_reg    <= 8'd0;
            offset_reg    <= 16'd0;
            kind_reg      <= KIND_DATA;
            acc_reg       <= 16'd0;
            seg_base_reg  <= 32'd0;
            lin_base_reg  <= 32'd0;
            base_sum_reg  <= 32'd0;
            count_reg     <= 8'd0;
            rec_addr_reg  <= 17'd0;
            total_reg     <= 32'd0;
            out_valid_reg <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            length_reg    <= length_next;
            offset_reg    <= offset_next;
            kind_reg      <= kind_next;
            acc_reg       <= acc_next;
            seg_base_reg  <= seg_base_next;
            lin_base_reg  <= lin_base_next;
            base_sum_reg  <= base_sum_next;
            count_reg     <= count_next;
            rec_addr_reg  <= rec_addr_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
        out_addr_reg   <= out_addr_next;
        out_byte_reg   <= out_byte_next;
        out_index_reg  <= out_index_next;
        out_total_reg  <= out_total_next;
        out_opened_reg <= out_opened_next;
        out_full_reg   <= out_full_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_total_reg, out_index_reg, out_byte_reg, out_addr_reg};
    assign m_tuser  = {out_full_reg, out_opened_reg};

endmodule

`default_nettype wire

@@ design/ihrl_ram.sv @@
// Generic single-port synchronous RAM with a registered read.
`default_nettype none

module ihrl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [WIDTH-1:0]  wdata,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

@@ design/ihrl_seg_ctrl.sv @@
// Segment table: find the segment that dst continues, open new ones, extend the current one.
`default_nettype none

module ihrl_seg_ctrl #(
    parameter int MAX_SEGMENTS = 16,
    parameter int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1,
    parameter int CNT_W = $clog2(MAX_SEGMENTS + 1)
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire ihrl_pkg::seg_req_t   req,
    input  wire logic [31:0]          dst,
    output ihrl_pkg::seg_status_t     status,
    output logic [IDX_W-1:0]          cur_index
);
    import ihrl_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_CMP  = 2'd2;

    localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(MAX_SEGMENTS);

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] cur_reg, cur_next;
    logic [31:0]      start_reg, start_next;
    logic [31:0]      len_reg, len_next;
    logic [31:0]      dst_reg, dst_next;
    logic [31:0]      probe_reg, probe_next;
    logic             opened_reg, opened_next;
    logic             dropped_reg, dropped_next;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_addr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [31:0]        rd_start;
    logic [31:0]        rd_len;
    logic [31:0]        rd_dist;

    assign rd_start = ram_rdata[63:32];
    assign rd_len   = ram_rdata[31:0];
    assign rd_dist  = probe_reg - rd_start;

    ihrl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_SEGMENTS),
        .ADDR_W(IDX_W)
    ) u_table (
        .aclk (aclk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        count_next   = count_reg;
        cur_next     = cur_reg;
        start_next   = start_reg;
        len_next     = len_reg;
        dst_next     = dst_reg;
        probe_next   = probe_reg;
        opened_next  = opened_reg;
        dropped_next = dropped_reg;
        ram_we       = 1'b0;
        ram_addr     = cur_reg;
        ram_wdata    = {start_reg, len_reg + 32'd1};

        unique case (state_reg)
            ST_IDLE: begin
                if (req.start) begin
                    dst_next   = dst;
                    idx_next   = '0;
                    state_next = ST_READ;
                end else if (req.emit) begin
                    opened_next = 1'b0;
                    // The current segment is cached; a byte not dropped writes its new length.
                    if (!dropped_reg) begin
                        ram_we   = 1'b1;
                        len_next = len_reg + 32'd1;
                    end
                end
            end
            ST_READ: begin
                probe_next = dst_reg - 32'd1;
                ram_addr   = idx_reg[IDX_W-1:0];
                if (idx_reg == count_reg) begin
                    state_next = ST_IDLE;
                    if (count_reg < COUNT_MAX) begin
                        ram_addr     = count_reg[IDX_W-1:0];
                        ram_we       = 1'b1;
                        ram_wdata    = {dst_reg, 32'd0};
                        cur_next     = count_reg[IDX_W-1:0];
                        start_next   = dst_reg;
                        len_next     = 32'd0;
                        count_next   = count_reg + CNT_W'(1);
                        opened_next  = 1'b1;
                        dropped_next = 1'b0;
                    end else begin
                        cur_next     = '0;
                        opened_next  = 1'b0;
                        dropped_next = 1'b1;
                    end
                end else begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                if (rd_dist < rd_len) begin
                    cur_next     = idx_reg[IDX_W-1:0];
                    start_next   = rd_start;
                    len_next     = rd_len;
                    opened_next  = 1'b0;
                    dropped_next = 1'b0;
                    state_next   = ST_IDLE;
                end else begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = ST_READ;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            count_reg   <= '0;
            cur_reg     <= '0;
            opened_reg  <= 1'b0;
            dropped_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            count_reg   <= count_next;
            cur_reg     <= cur_next;
            opened_reg  <= opened_next;
            dropped_reg <= dropped_next;
        end
        start_reg <= start_next;
        len_reg   <= len_next;
        dst_reg   <= dst_next;
        probe_reg <= probe_next;
    end

    assign status.busy    = (state_reg != ST_IDLE);
    assign status.opened  = opened_reg;
    assign status.dropped = dropped_reg;
    assign cur_index      = cur_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_MAX)
        else $error("segment count exceeds table depth");

    a_open_drop_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(opened_reg && dropped_reg))
        else $error("segment both opened and dropped");

    a_cmp_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CMP) |-> (idx_reg < count_reg))
        else $error("search compares an entry beyond the table fill");

    a_count_grows_on_open: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ && idx_reg == count_reg && count_reg < COUNT_MAX)
        |=> (count_reg == $past(count_reg) + CNT_W'(1)) && opened_reg)
        else $error("failed search did not open a segment");
`endif

endmodule

`default_nettype wire
